>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/pcg_pkg.sv
// Types, constants and saturating fixed-point helpers for the CG Poisson solver.
package pcg_pkg;

	localparam int GRID_MAX_DEF  = 32;
	localparam int FRAC_BITS_DEF = 60;

	localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [0:0] {
		DS_DIV,
		DS_SQRT
	} ds_op_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_RUN,
		DS_ROUND,
		DS_DONE
	} ds_state_t;

	typedef enum logic [2:0] {
		MS_IDLE,
		MS_PROD,
		MS_ROUND,
		MS_SAT,
		MS_DONE
	} mul_state_t;

	typedef enum logic [2:0] {
		TAP_C,
		TAP_L,
		TAP_R,
		TAP_U,
		TAP_D,
		TAP_END
	} tap_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_READ,
		S_CLR,
		S_DEN1,
		S_DEN2,
		S_RHS_NUM,
		S_RHS_DIV,
		S_RHS_DWAIT,
		S_RHS_MUL,
		S_RHS_MWAIT,
		S_ITER,
		S_ST_ADDR,
		S_ST_DATA,
		S_DQ_RD,
		S_DQ_MUL,
		S_DQ_WAIT,
		S_TAU,
		S_TAU_WAIT,
		S_UP_RD,
		S_UP_M1,
		S_UP_W1,
		S_UP_M2,
		S_UP_W2,
		S_UP_M3,
		S_UP_W3,
		S_BETA,
		S_BETA_WAIT,
		S_DR_RD,
		S_DR_MUL,
		S_DR_WAIT,
		S_SQRT,
		S_SQ_WAIT,
		S_DONE
	} pcg_state_t;

	function automatic tap_t tap_next(input tap_t t);
		tap_t n;
		unique case (t)
			TAP_C:   n = TAP_L;
			TAP_L:   n = TAP_R;
			TAP_R:   n = TAP_U;
			TAP_U:   n = TAP_D;
			TAP_D:   n = TAP_END;
			default: n = TAP_END;
		endcase
		return n;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			return a[63] ? SAT_MIN : SAT_MAX;
		return r;
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63])
			return a[63] ? SAT_MIN : SAT_MAX;
		return r;
	endfunction

	function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
		return sat_sub(64'sd0, a);
	endfunction

	// Four times x, clamped: fits when the top three bits agree.
	function automatic logic signed [63:0] clamp4(input logic signed [63:0] x);
		if (x[63] == x[62] && x[62] == x[61])
			return {x[61:0], 2'b00};
		return x[63] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic signed [63:0] from_mag(input logic ovf, input logic [63:0] m,
		input logic neg);
		if (neg)
			return (ovf || m[63]) ? SAT_MIN : -signed'(m);
		return (ovf || m[63]) ? SAT_MAX : signed'(m);
	endfunction

endpackage

>>> hw/rtl/poisson_cg_solver.sv
// Top level: sequencer, grid stores and shared units of the CG Poisson solver.
// Read item: the entry is read in the transfer cycle, then registered as the result and
//   loaded into the output register. Start item: run time grows with iteration_count and n^2,
//   set by the 128-step divider per right-hand-side entry and the multiplier in each grid pass.
// One item at a time; in_stall stays high until the result sits in the output register.
// arst_n clears the sequencer, sets grid_size to 32 and marks the solution as all zero.
`include "assert_macros.svh"

module poisson_cg_solver #(
	parameter int GRID_MAX  = pcg_pkg::GRID_MAX_DEF,
	parameter int FRAC_BITS = pcg_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [9:0]         iteration_count,
	input  logic [9:0]         entry_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] value,
	output logic               is_norm
);
	import pcg_pkg::*;

	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(CELLS);
	localparam int NW    = $clog2(GRID_MAX + 1);
	localparam int NW1   = $clog2(GRID_MAX + 2);
	localparam int NUMW  = 2 * NW1 + 2;
	localparam int DENW  = 4 * NW1;
	localparam logic [AW-1:0] KLAST = AW'(CELLS - 1);

	// Sequencer and configuration
	pcg_state_t state_q, state_d;
	logic [5:0]    grid_size_q;
	logic          solved_q;
	logic          accept;
	logic          out_free;

	// Loop counters
	logic [NW-1:0] n_q, r_q, c_q;
	logic [AW-1:0] k_q;
	logic [9:0]    it_q;
	tap_t          tap_q;
	logic          tap_use;
	logic [AW-1:0] tap_addr;
	logic          last_cell;
	logic          step_cell;

	// Right-hand-side terms
	logic [2*NW1-1:0] sq_q;
	logic [DENW-1:0]  den_q;
	logic [NUMW-1:0]  num_q;
	logic [NW1-1:0]   np1, c1, nc, r1, nr;

	// Scalars
	logic signed [63:0] q0_q, q1_q, dq_q, tau_q, beta_q, g_q, ng_q, v_q;
	logic signed [63:0] res_q;
	logic               res_norm_q;
	logic               rd_ok_q;

	// Grid stores
	logic          re;
	logic [AW-1:0] rd_addr;
	logic          u_we, d_we, g_we, p_we;
	logic signed [63:0] u_wdata, d_wdata, g_wdata, p_wdata;
	logic signed [63:0] u_rd, d_rd, g_rd, p_rd;

	// Shared units
	logic               mul_start, ds_start;
	logic signed [63:0] mul_a, mul_b, mul_res;
	logic signed [63:0] ds_a, ds_b, ds_res;
	ds_op_t             ds_op;
	unit_stat_t         mul_st, div_st;

	// Entry lookup
	logic [31:0] idx_ext;
	logic        entry_ok;
	logic [AW-1:0] entry_addr;
	logic [31:0] gs_ext;
	logic [NW-1:0] n_clamp;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	assign idx_ext    = 32'(entry_index);
	assign entry_ok   = (idx_ext < CELLS);
	assign entry_addr = idx_ext[AW-1:0];

	// Clamp the configured size to the built grid.
	assign gs_ext  = 32'(grid_size_q);
	assign n_clamp = (gs_ext < 2) ? NW'(2) : ((gs_ext > GRID_MAX) ? NW'(GRID_MAX) : NW'(gs_ext));

	assign last_cell = (r_q == n_q - NW'(1)) && (c_q == n_q - NW'(1));

	assign np1 = NW1'(n_q) + NW1'(1);
	assign c1  = NW1'(c_q) + NW1'(1);
	assign nc  = NW1'(n_q - c_q);
	assign r1  = NW1'(r_q) + NW1'(1);
	assign nr  = NW1'(n_q - r_q);

	// Stencil taps: centre, then the four neighbours that lie inside the grid.
	always_comb begin
		tap_use  = 1'b0;
		tap_addr = k_q;
		unique case (tap_q)
			TAP_C: tap_use = 1'b1;
			TAP_L: begin
				tap_use  = (c_q != '0);
				tap_addr = k_q - AW'(1);
			end
			TAP_R: begin
				tap_use  = (c_q != n_q - NW'(1));
				tap_addr = k_q + AW'(1);
			end
			TAP_U: begin
				tap_use  = (r_q != '0);
				tap_addr = k_q - AW'(n_q);
			end
			TAP_D: begin
				tap_use  = (r_q != n_q - NW'(1));
				tap_addr = k_q + AW'(n_q);
			end
			default: tap_use = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = (kind == KIND_READ) ? S_READ : S_CLR;
			S_READ:      state_d = S_DONE;
			S_CLR:       if (k_q == KLAST) state_d = S_DEN1;
			S_DEN1:      state_d = S_DEN2;
			S_DEN2:      state_d = S_RHS_NUM;
			S_RHS_NUM:   state_d = S_RHS_DIV;
			S_RHS_DIV:   state_d = S_RHS_DWAIT;
			S_RHS_DWAIT: if (div_st.done) state_d = S_RHS_MUL;
			S_RHS_MUL:   state_d = S_RHS_MWAIT;
			S_RHS_MWAIT: if (mul_st.done) state_d = last_cell ? S_ITER : S_RHS_NUM;
			S_ITER:      state_d = (it_q == 10'd0) ? S_SQRT : S_ST_ADDR;
			S_ST_ADDR: begin
				if (tap_q == TAP_END) begin
					if (last_cell)
						state_d = S_DQ_RD;
				end else if (tap_use) begin
					state_d = S_ST_DATA;
				end
			end
			S_ST_DATA:   state_d = S_ST_ADDR;
			S_DQ_RD:     state_d = S_DQ_MUL;
			S_DQ_MUL:    state_d = S_DQ_WAIT;
			S_DQ_WAIT:   if (mul_st.done) state_d = last_cell ? S_TAU : S_DQ_RD;
			S_TAU:       state_d = S_TAU_WAIT;
			S_TAU_WAIT:  if (div_st.done) state_d = S_UP_RD;
			S_UP_RD:     state_d = S_UP_M1;
			S_UP_M1:     state_d = S_UP_W1;
			S_UP_W1:     if (mul_st.done) state_d = S_UP_M2;
			S_UP_M2:     state_d = S_UP_W2;
			S_UP_W2:     if (mul_st.done) state_d = S_UP_M3;
			S_UP_M3:     state_d = S_UP_W3;
			S_UP_W3:     if (mul_st.done) state_d = last_cell ? S_BETA : S_UP_RD;
			S_BETA:      state_d = S_BETA_WAIT;
			S_BETA_WAIT: if (div_st.done) state_d = S_DR_RD;
			S_DR_RD:     state_d = S_DR_MUL;
			S_DR_MUL:    state_d = S_DR_WAIT;
			S_DR_WAIT:   if (mul_st.done) state_d = last_cell ? S_ITER : S_DR_RD;
			S_SQRT:      state_d = S_SQ_WAIT;
			S_SQ_WAIT:   if (div_st.done) state_d = S_DONE;
			S_DONE:      if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Store ports, unit starts and operands
	always_comb begin
		re        = 1'b0;
		rd_addr   = k_q;
		u_we      = 1'b0;
		d_we      = 1'b0;
		g_we      = 1'b0;
		p_we      = 1'b0;
		u_wdata   = sat_add(u_rd, mul_res);
		d_wdata   = sat_add(ng_q, mul_res);
		g_wdata   = sat_add(g_rd, mul_res);
		p_wdata   = v_q;
		mul_start = 1'b0;
		mul_a     = tau_q;
		mul_b     = d_rd;
		ds_start  = 1'b0;
		ds_op     = DS_DIV;
		ds_a      = q0_q;
		ds_b      = dq_q;
		step_cell = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// Fetch the solution entry in the transfer cycle itself.
				if (in_valid && kind == KIND_READ) begin
					re      = 1'b1;
					rd_addr = entry_addr;
				end
			end
			S_CLR: begin
				u_we    = 1'b1;
				u_wdata = 64'sd0;
			end
			S_RHS_DIV: begin
				ds_start = 1'b1;
				ds_a     = 64'(num_q);
				ds_b     = 64'(den_q);
			end
			S_RHS_DWAIT: begin
				// Direction starts at b, residual at -b.
				if (div_st.done) begin
					d_we    = 1'b1;
					d_wdata = ds_res;
					g_we    = 1'b1;
					g_wdata = sat_neg(ds_res);
				end
			end
			S_RHS_MUL: begin
				mul_start = 1'b1;
				mul_a     = g_q;
				mul_b     = g_q;
			end
			S_RHS_MWAIT: step_cell = mul_st.done;
			S_ST_ADDR: begin
				if (tap_q == TAP_END) begin
					p_we      = 1'b1;
					step_cell = 1'b1;
				end else if (tap_use) begin
					re      = 1'b1;
					rd_addr = tap_addr;
				end
			end
			S_DQ_RD: re = 1'b1;
			S_DQ_MUL: begin
				mul_start = 1'b1;
				mul_a     = d_rd;
				mul_b     = p_rd;
			end
			S_DQ_WAIT: step_cell = mul_st.done;
			S_TAU:     ds_start = 1'b1;
			S_UP_RD:   re = 1'b1;
			S_UP_M1:   mul_start = 1'b1;
			S_UP_W1:   u_we = mul_st.done;
			S_UP_M2: begin
				mul_start = 1'b1;
				mul_b     = p_rd;
			end
			S_UP_W2:   g_we = mul_st.done;
			S_UP_M3: begin
				mul_start = 1'b1;
				mul_a     = g_q;
				mul_b     = g_q;
			end
			S_UP_W3:   step_cell = mul_st.done;
			S_BETA: begin
				ds_start = 1'b1;
				ds_a     = q1_q;
				ds_b     = q0_q;
			end
			S_DR_RD:   re = 1'b1;
			S_DR_MUL: begin
				mul_start = 1'b1;
				mul_a     = beta_q;
			end
			S_DR_WAIT: begin
				d_we      = mul_st.done;
				step_cell = mul_st.done;
			end
			S_SQRT: begin
				ds_start = 1'b1;
				ds_op    = DS_SQRT;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			grid_size_q <= 6'd32;
			solved_q    <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				grid_size_q <= cfg_data;
			// After a start the whole solution store holds defined data.
			if (accept && kind == KIND_START)
				solved_q <= 1'b1;
			if (state_q == S_DONE && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Walk the grid row-major and wrap to the first cell after the last.
		if (step_cell) begin
			if (last_cell) begin
				r_q <= '0;
				c_q <= '0;
				k_q <= '0;
			end else begin
				if (c_q == n_q - NW'(1)) begin
					c_q <= '0;
					r_q <= r_q + NW'(1);
				end else begin
					c_q <= c_q + NW'(1);
				end
				k_q <= k_q + AW'(1);
			end
		end

		if (state_q == S_DONE && out_free) begin
			value   <= res_q;
			is_norm <= res_norm_q;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_ok_q <= solved_q && entry_ok;
					n_q     <= n_clamp;
					it_q    <= iteration_count;
					k_q     <= '0;
				end
			end
			S_READ: begin
				res_q      <= rd_ok_q ? u_rd : 64'sd0;
				res_norm_q <= 1'b0;
			end
			S_CLR:  k_q <= k_q + AW'(1);
			S_DEN1: sq_q <= (2*NW1)'(np1 * np1);
			S_DEN2: begin
				den_q <= DENW'(sq_q * sq_q);
				r_q   <= '0;
				c_q   <= '0;
				k_q   <= '0;
				q0_q  <= 64'sd0;
			end
			S_RHS_NUM: num_q <= (NUMW'(c1 * nc) + NUMW'(r1 * nr)) << 1;
			S_RHS_DWAIT: if (div_st.done) g_q <= sat_neg(ds_res);
			S_RHS_MWAIT: if (mul_st.done) q0_q <= sat_add(q0_q, mul_res);
			S_ITER: begin
				tap_q <= TAP_C;
				dq_q  <= 64'sd0;
				q1_q  <= 64'sd0;
				if (it_q != 10'd0)
					it_q <= it_q - 10'd1;
			end
			S_ST_ADDR: begin
				if (tap_q == TAP_END)
					tap_q <= TAP_C;
				else if (!tap_use)
					tap_q <= tap_next(tap_q);
			end
			S_ST_DATA: begin
				// Centre is 4d clamped, then subtract each neighbour with saturation.
				v_q   <= (tap_q == TAP_C) ? clamp4(d_rd) : sat_sub(v_q, d_rd);
				tap_q <= tap_next(tap_q);
			end
			S_DQ_WAIT:   if (mul_st.done) dq_q <= sat_add(dq_q, mul_res);
			S_TAU_WAIT:  if (div_st.done) tau_q <= ds_res;
			S_UP_W2:     if (mul_st.done) g_q <= sat_add(g_rd, mul_res);
			S_UP_W3:     if (mul_st.done) q1_q <= sat_add(q1_q, mul_res);
			S_BETA_WAIT: if (div_st.done) beta_q <= ds_res;
			S_DR_MUL:    ng_q <= sat_neg(g_rd);
			S_DR_WAIT:   if (mul_st.done && last_cell) q0_q <= q1_q;
			S_SQ_WAIT: begin
				if (div_st.done) begin
					res_q      <= ds_res;
					res_norm_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Solution u, direction d, residual g, stencil product p
	pcg_ram #(.WIDTH(64), .DEPTH(CELLS)) u_sol (
		.clk(clk), .we(u_we), .waddr(k_q), .wdata(u_wdata),
		.re(re), .raddr(rd_addr), .rdata(u_rd)
	);

	pcg_ram #(.WIDTH(64), .DEPTH(CELLS)) u_dir (
		.clk(clk), .we(d_we), .waddr(k_q), .wdata(d_wdata),
		.re(re), .raddr(rd_addr), .rdata(d_rd)
	);

	pcg_ram #(.WIDTH(64), .DEPTH(CELLS)) u_res (
		.clk(clk), .we(g_we), .waddr(k_q), .wdata(g_wdata),
		.re(re), .raddr(rd_addr), .rdata(g_rd)
	);

	pcg_ram #(.WIDTH(64), .DEPTH(CELLS)) u_prod (
		.clk(clk), .we(p_we), .waddr(k_q), .wdata(p_wdata),
		.re(re), .raddr(rd_addr), .rdata(p_rd)
	);

	pcg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.stat(mul_st), .result(mul_res)
	);

	pcg_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_divsqrt (
		.clk(clk), .arst_n(arst_n), .start(ds_start), .op(ds_op), .a(ds_a), .b(ds_b),
		.stat(div_st), .result(ds_res)
	);

	`ASSERT_NEXT(a_start_clears, clk, arst_n, accept && kind == KIND_START, state_q == S_CLR)
	`ASSERT_IMPL(a_mul_free, clk, arst_n, mul_start, !mul_st.busy)
	`ASSERT_IMPL(a_div_free, clk, arst_n, ds_start, !div_st.busy)
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, state_q == S_DONE && out_free, out_valid)

endmodule

>>> hw/rtl/pcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/pcg_mul.sv
// Multi-cycle Q-format multiplier: four 32x32 partial products, round, saturate.
module pcg_mul #(
	parameter int FRAC_BITS = pcg_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output pcg_pkg::unit_stat_t stat,
	output logic signed [63:0]  result
);
	import pcg_pkg::*;

	localparam logic [127:0] HALF = 128'(1) << (FRAC_BITS - 1);

	mul_state_t state_q, state_d;
	logic [63:0]  am_q, bm_q;
	logic         neg_q;
	logic [1:0]   idx_q;
	logic [127:0] acc_q;
	logic [31:0]  a_half, b_half;
	logic [63:0]  pp;
	logic [6:0]   sh;
	logic [127:0] rsh;

	assign a_half = idx_q[1] ? am_q[63:32] : am_q[31:0];
	assign b_half = idx_q[0] ? bm_q[63:32] : bm_q[31:0];
	assign pp     = a_half * b_half;
	assign sh     = 7'({1'b0, idx_q[1]} + {1'b0, idx_q[0]}) << 5;
	assign rsh    = acc_q >> FRAC_BITS;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MS_IDLE:  if (start) state_d = MS_PROD;
			MS_PROD:  if (idx_q == 2'd3) state_d = MS_ROUND;
			MS_ROUND: state_d = MS_SAT;
			MS_SAT:   state_d = MS_DONE;
			MS_DONE:  state_d = MS_IDLE;
			default:  state_d = MS_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != MS_IDLE);
		stat.done = (state_q == MS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			MS_IDLE: begin
				if (start) begin
					am_q  <= mag(a);
					bm_q  <= mag(b);
					neg_q <= a[63] ^ b[63];
					idx_q <= 2'd0;
					acc_q <= '0;
				end
			end
			MS_PROD: begin
				acc_q <= acc_q + (128'(pp) << sh);
				idx_q <= idx_q + 2'd1;
			end
			MS_ROUND: acc_q <= acc_q + HALF;
			MS_SAT:   result <= from_mag(|rsh[127:64], rsh[63:0], neg_q);
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/pcg_divsqrt.sv
// Shared iterative unit: rounded fixed-point divide and integer square root.
module pcg_divsqrt #(
	parameter int FRAC_BITS = pcg_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pcg_pkg::ds_op_t     op,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output pcg_pkg::unit_stat_t stat,
	output logic signed [63:0]  result
);
	import pcg_pkg::*;

	ds_state_t state_q, state_d;
	ds_op_t       op_q;
	logic [127:0] num_q;
	logic [65:0]  rem_q;
	logic [63:0]  quo_q;
	logic [63:0]  d_q;
	logic         ovf_q;
	logic         neg_q;
	logic [6:0]   cnt_q;
	logic         trivial;
	logic [65:0]  rem_sh, sub_v, diff;
	logic         ge;
	logic         rnd;
	logic [64:0]  mag65;

	// Quotient by zero and root of a non-positive value are both zero.
	assign trivial = (op == DS_DIV) ? (b == 64'sd0) : (a[63] || a == 64'sd0);

	// One compare and subtract per step, shared by both operations.
	assign rem_sh = (op_q == DS_DIV) ? {rem_q[64:0], num_q[127]}
		: {rem_q[63:0], num_q[127:126]};
	assign sub_v  = (op_q == DS_DIV) ? {2'b00, d_q} : {quo_q, 2'b01};
	assign ge     = (rem_sh >= sub_v);
	assign diff   = rem_sh - sub_v;

	assign rnd   = ({rem_q, 1'b0} >= {3'b000, d_q});
	assign mag65 = {1'b0, quo_q} + 65'(rnd);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DS_IDLE:  if (start) state_d = trivial ? DS_DONE : DS_RUN;
			DS_RUN:   if (cnt_q == 7'd0) state_d = DS_ROUND;
			DS_ROUND: state_d = DS_DONE;
			DS_DONE:  state_d = DS_IDLE;
			default:  state_d = DS_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != DS_IDLE);
		stat.done = (state_q == DS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DS_IDLE: begin
				if (start) begin
					op_q  <= op;
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					d_q   <= mag(b);
					neg_q <= a[63] ^ b[63];
					if (trivial)
						result <= 64'sd0;
					if (op == DS_DIV) begin
						num_q <= 128'(mag(a)) << FRAC_BITS;
						cnt_q <= 7'd127;
					end else begin
						num_q <= 128'(a) << FRAC_BITS;
						cnt_q <= 7'd63;
					end
				end
			end
			DS_RUN: begin
				rem_q <= ge ? diff : rem_sh;
				quo_q <= {quo_q[62:0], ge};
				cnt_q <= cnt_q - 7'd1;
				if (op_q == DS_DIV) begin
					ovf_q <= ovf_q | quo_q[63];
					num_q <= {num_q[126:0], 1'b0};
				end else begin
					num_q <= {num_q[125:0], 2'b00};
				end
			end
			DS_ROUND: begin
				if (op_q == DS_DIV)
					result <= from_mag(ovf_q | mag65[64], mag65[63:0], neg_q);
				else
					result <= signed'(quo_q);
			end
			default: ;
		endcase
	end

endmodule

>>> bench/tb.sv
// Self-checking testbench for the conjugate-gradient Poisson solver.
`timescale 1ns / 100ps

module tb;
	import pcg_pkg::*;

	typedef logic signed [63:0] fx_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;

	typedef struct {
		row_op_t    op;
		logic       kind;
		logic [9:0] iters;
		logic [9:0] index;
		logic [5:0] size;
		logic       typed;
		fx_t        want;
	} stim_row_t;

	typedef struct {
		fx_t  value;
		logic is_norm;
	} answer_t;

	localparam int   CELLS   = GRID_MAX_DEF * GRID_MAX_DEF;
	localparam int   FB      = FRAC_BITS_DEF;
	localparam fx_t  FX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam fx_t  FX_MIN  = 64'sh8000_0000_0000_0000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [5:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       kind = KIND_READ;
	logic [9:0] iteration_count = '0;
	logic [9:0] entry_index = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	fx_t        value;
	logic       is_norm;

	poisson_cg_solver dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .iteration_count(iteration_count), .entry_index(entry_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .is_norm(is_norm)
	);

	// Predictor state: the solver's grids and its size register.
	fx_t        sol_grid [CELLS];
	fx_t        dir_grid [CELLS];
	fx_t        res_grid [CELLS];
	fx_t        lap_grid [CELLS];
	logic [5:0] size_reg = 6'd32;

	answer_t    answers_due [$];
	stim_row_t  plan [$];
	int         errors = 0;
	longint     cycles = 0;
	longint     budget = 200000;
	int         tx_idle = 0;
	int         rx_idle = 0;
	bit         hold_req = 0;
	int         hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// ---------------- fixed-point arithmetic, saturating ----------------

	function automatic logic [63:0] abs_u(input fx_t a);
		return a[63] ? 64'd0 - a : a;
	endfunction

	// Clamp an unsigned 128-bit magnitude with a sign into the 64-bit range.
	function automatic fx_t clip_mag(input logic [127:0] m, input logic neg);
		if (neg)
			return (m >= 128'h8000_0000_0000_0000) ? FX_MIN : -fx_t'(m[63:0]);
		return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? FX_MAX : fx_t'(m[63:0]);
	endfunction

	function automatic fx_t add_sat(input fx_t a, input fx_t b);
		logic signed [64:0] s;
		s = a + b;
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return FX_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return FX_MIN;
		return s[63:0];
	endfunction

	function automatic fx_t sub_sat(input fx_t a, input fx_t b);
		logic signed [64:0] s;
		s = a - b;
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return FX_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return FX_MIN;
		return s[63:0];
	endfunction

	function automatic fx_t mul_rnd(input fx_t a, input fx_t b);
		logic [127:0] p;
		p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
		p = (p + (128'd1 << (FB - 1))) >> FB;
		return clip_mag(p, a[63] != b[63]);
	endfunction

	// Quotient of magnitudes, rounded half away from zero.
	function automatic logic [127:0] div_rnd(input logic [127:0] num, input logic [63:0] den);
		logic [127:0] q, r, d;
		d = {64'd0, den};
		q = num / d;
		r = num % d;
		if (r >= d - r) q = q + 1;
		return q;
	endfunction

	function automatic fx_t quot(input fx_t a, input fx_t b);
		if (b == 0) return 0;
		return clip_mag(div_rnd({64'd0, abs_u(a)} << FB, abs_u(b)), a[63] != b[63]);
	endfunction

	function automatic fx_t root(input fx_t v);
		logic [127:0] n, t;
		logic [63:0]  res;
		res = 0;
		if (v <= 0) return 0;
		n = {64'd0, v} << FB;
		for (int bit_i = 62; bit_i >= 0; bit_i--) begin
			t = {64'd0, res | (64'd1 << bit_i)};
			if (t * t <= n) res = t[63:0];
		end
		return fx_t'(res);
	endfunction

	function automatic int side_of(input logic [5:0] s);
		if (s < 2) return 2;
		if (s > GRID_MAX_DEF) return GRID_MAX_DEF;
		return s;
	endfunction

	// Full CG solve on the predictor grids; returns the residual norm.
	function automatic fx_t solve_norm(input int iters);
		int  n, k;
		fx_t q0, q1, dq, tau, beta, v;
		logic [63:0] den, num;
		n = side_of(size_reg);
		den = (n + 1) * (n + 1) * (n + 1) * (n + 1);
		q0 = 0;
		foreach (sol_grid[i]) sol_grid[i] = 0;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				k = r * n + c;
				num = 2 * ((c + 1) * (n - c) + (r + 1) * (n - r));
				dir_grid[k] = clip_mag(div_rnd({64'd0, num} << FB, den), 1'b0);
				res_grid[k] = sub_sat(0, dir_grid[k]);
				q0 = add_sat(q0, mul_rnd(res_grid[k], res_grid[k]));
			end
		for (int it = 0; it < iters; it++) begin
			dq = 0;
			q1 = 0;
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++) begin
					k = r * n + c;
					v = add_sat(dir_grid[k], dir_grid[k]);
					v = add_sat(v, v);
					if (c > 0)     v = sub_sat(v, dir_grid[k - 1]);
					if (c + 1 < n) v = sub_sat(v, dir_grid[k + 1]);
					if (r > 0)     v = sub_sat(v, dir_grid[k - n]);
					if (r + 1 < n) v = sub_sat(v, dir_grid[k + n]);
					lap_grid[k] = v;
				end
			for (k = 0; k < n * n; k++)
				dq = add_sat(dq, mul_rnd(dir_grid[k], lap_grid[k]));
			tau = quot(q0, dq);
			for (k = 0; k < n * n; k++) begin
				sol_grid[k] = add_sat(sol_grid[k], mul_rnd(tau, dir_grid[k]));
				res_grid[k] = add_sat(res_grid[k], mul_rnd(tau, lap_grid[k]));
				q1 = add_sat(q1, mul_rnd(res_grid[k], res_grid[k]));
			end
			beta = quot(q1, q0);
			for (k = 0; k < n * n; k++)
				dir_grid[k] = add_sat(sub_sat(0, res_grid[k]), mul_rnd(beta, dir_grid[k]));
			q0 = q1;
		end
		return root(q0);
	endfunction

	// ---------------- stimulus ----------------

	function automatic stim_row_t row(input row_op_t op, input logic k, input int it,
		input int idx, input int sz, input logic typed, input fx_t want);
		stim_row_t r;
		r.op = op; r.kind = k; r.iters = 10'(it); r.index = 10'(idx); r.size = 6'(sz);
		r.typed = typed; r.want = want;
		return r;
	endfunction

	// Hold off until every expected result has come back.
	task automatic drain();
		while (answers_due.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_size(input logic [5:0] sz);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = sz;
		@(negedge clk);
		cfg_we = 1'b0;
		size_reg = sz;
	endtask

	// Offer one item, wait for its transfer, then queue its expected result.
	task automatic offer(input logic k, input logic [9:0] it, input logic [9:0] idx,
		input logic typed, input fx_t want);
		answer_t a;
		int n;
		@(negedge clk);
		if ($urandom_range(99) < tx_idle) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		iteration_count = it;
		entry_index = idx;
		// Grow the watchdog budget by a generous bound for this item.
		n = side_of(size_reg);
		if (k == KIND_START)
			budget += 2 * (CELLS + 140 * n * n + it * (62 * n * n + 270) + 75) + 3000;
		else
			budget += 3000;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		if (k == KIND_START) begin
			a.value = solve_norm(it);
			a.is_norm = 1'b1;
		end else begin
			a.value = (idx < CELLS) ? sol_grid[idx] : 0;
			a.is_norm = 1'b0;
		end
		if (typed) a.value = want;
		answers_due.push_back(a);
		// Drop valid once the item has transferred.
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic random_items(input int count, input bit pause_midway);
		int n;
		for (int i = 0; i < count; i++) begin
			n = side_of(size_reg);
			if (pause_midway && i == count / 2) drain();
			if ($urandom_range(99) < 40)
				offer(KIND_START, 10'($urandom_range(0, 6)), 10'($urandom_range(0, 1023)),
					0, 0);
			else if ($urandom_range(99) < 80)
				offer(KIND_READ, 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, n * n - 1)), 0, 0);
			else
				offer(KIND_READ, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
					0, 0);
		end
	endtask

	// Receiver: random stall, or a long hold-off when the driver asks for one.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left = 300;
			out_stall = 1'b1;
		end else
			out_stall = ($urandom_range(99) < rx_idle);
	end

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$error("result with no expectation: value %0d is_norm %0b", value, is_norm);
				errors++;
			end else begin
				a = answers_due.pop_front();
				if (value !== a.value) begin
					$error("value: expected %0d, got %0d", a.value, value);
					errors++;
				end
				if (is_norm !== a.is_norm) begin
					$error("is_norm: expected %0b, got %0b", a.is_norm, is_norm);
					errors++;
				end
			end
		end
	end

	// Watchdog: the budget grows with each offered item.
	always @(posedge clk) begin
		cycles++;
		if (cycles > budget + 100000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		// Directed plan: reset reads, clamped sizes, zero and full iteration counts.
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 0, 0, 1, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 1023, 1023, 0, 1, 0));
		plan.push_back(row(ROW_CFG, 0, 0, 0, 2, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_START, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_START, 1, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 3, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 4, 0, 1, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 1023, 0, 1, 0));
		plan.push_back(row(ROW_CFG, 0, 0, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_START, 2, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 1, 0, 0, 0));
		plan.push_back(row(ROW_CFG, 0, 0, 0, 63, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_START, 1, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 1023, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 33, 0, 0, 0));
		plan.push_back(row(ROW_CFG, 0, 0, 0, 1, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_START, 3, 0, 0, 0, 0));
		plan.push_back(row(ROW_CFG, 0, 0, 0, 2, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_START, 1023, 0, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 2, 0, 0, 0));
		plan.push_back(row(ROW_ITEM, KIND_READ, 0, 1022, 0, 1, 0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase one: sender idles lightly, receiver heavily.
		tx_idle = 20;
		rx_idle = 68;
		foreach (plan[i]) begin
			if (plan[i].op == ROW_CFG)
				write_size(plan[i].size);
			else
				offer(plan[i].kind, plan[i].iters, plan[i].index, plan[i].typed, plan[i].want);
		end
		write_size(6'($urandom_range(2, 6)));
		random_items(33, 0);

		// Phase two: swap the idling; open with a long receiver hold-off while items wait behind a held result.
		write_size(6'($urandom_range(0, 6)));
		tx_idle = 68;
		rx_idle = 20;
		hold_req = 1;
		random_items(34, 0);

		// Phase three: full rate, with one pause until everything has drained.
		write_size(6'($urandom_range(2, 5)));
		tx_idle = 0;
		rx_idle = 0;
		random_items(33, 1);

		@(negedge clk);
		in_valid = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
